// ===== hw/rtl/uas_pkg.sv =====
package uas_pkg;

    // Default number of cells held in the row store
    localparam int MAX_CELLS_DEF = 32;

    // Field widths fixed by the interface
    localparam int FRAC_W = 16;
    localparam int VEL_W  = 24;
    localparam int DT_W   = 24;
    localparam int ICS_W  = 24;
    localparam int CNT_W  = 6;
    localparam int POS_W  = 5;
    localparam int COUR_W = 32;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 24;

    // Configuration register indexes
    localparam logic CFG_CELL_COUNT  = 1'b0;
    localparam logic CFG_INV_SPACING = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] CELL_COUNT_RST  = CNT_W'(10);
    localparam logic [ICS_W-1:0] INV_SPACING_RST = ICS_W'(256);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch the accepted time step
        logic mul1;   // velocity times step length
        logic mul2;   // times inverse spacing
        logic csat;   // saturate the Courant number
        logic step;   // one sweep step: shift the neighbour window
        logic rd_en;  // read one old cell value
        logic comp;   // start the update of one cell
        logic first;  // the cell being updated is cell 0
        logic last;   // the cell being updated is the last in use
    } t_cmd;

endpackage

// ===== hw/rtl/upwind_advection_step_unit.sv =====
// A transferred time step passes the states MUL1, MUL2 and SAT; the sweep then reads
// the old cells and feeds update stage one and the output register, with one result
// per cycle while it runs; the single read port of the row store sets this pace, and a
// stalled output holds the whole datapath. A new time step is taken once the sweep ends.
// Reset (synchronous, active low) empties the pipeline, marks all cells as zero and
// sets cell_count to 10 and inverse_cell_spacing to 256.
module upwind_advection_step_unit
    import uas_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Time step transfer
    input  logic                s_tvalid,
    output logic                s_tready,
    // velocity [23:0], time_step [47:24], inflow_fraction [63:48],
    // outflow_fraction [79:64]
    input  logic [S_DATA_W-1:0] s_tdata,
    // Cell result transfer
    output logic                m_tvalid,
    input  logic                m_tready,
    // cell_value [15:0], cell_position [20:16], zero [23:21]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    // Configuration writes
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [ICS_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);

    logic [CNT_W-1:0]  r_cell_count;
    logic [ICS_W-1:0]  r_inv_spacing;
    logic              accept;
    logic              idle;
    logic              adv;
    t_cmd              cmd;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     comp_idx;
    logic [FRAC_W-1:0] cell_value;
    logic [POS_W-1:0]  cell_position;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count  <= CELL_COUNT_RST;
            r_inv_spacing <= INV_SPACING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELL_COUNT:  r_cell_count  <= i_cfg_data[CNT_W-1:0];
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = idle;
    assign accept   = s_tvalid && idle;

    uas_ctrl #(
        .MAX_CELLS (MAX_CELLS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_adv        (adv),
        .i_cell_count (r_cell_count),
        .o_idle       (idle),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr),
        .o_comp_idx   (comp_idx)
    );

    uas_dpath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .i_comp_idx      (comp_idx),
        .i_item          (s_tdata),
        .i_inv_spacing   (r_inv_spacing),
        .i_out_ready     (m_tready),
        .o_adv           (adv),
        .o_out_valid     (m_tvalid),
        .o_cell_value    (cell_value),
        .o_cell_position (cell_position),
        .o_last_cell     (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {3'b000, cell_position, cell_value};

endmodule

// ===== hw/rtl/uas_ctrl.sv =====
module uas_ctrl
    import uas_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_adv,
    input  logic [CNT_W-1:0]             i_cell_count,
    output logic                         o_idle,
    output t_cmd                         o_cmd,
    output logic [$clog2(MAX_CELLS)-1:0] o_rd_addr,
    output logic [$clog2(MAX_CELLS)-1:0] o_comp_idx
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int KW = $clog2(MAX_CELLS + 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_SAT   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [KW-1:0] r_n, n_n;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] clamp_n;
    logic [KW-1:0] k_m2;

    // Cell count limited to the range two to capacity
    always_comb begin
        if (i_cell_count < CNT_W'(2)) begin
            clamp_n = KW'(2);
        end else if (int'(i_cell_count) > MAX_CELLS) begin
            clamp_n = KW'(MAX_CELLS);
        end else begin
            clamp_n = KW'(i_cell_count);
        end
    end

    assign k_m2 = r_k - KW'(2);

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_k        = r_k;
        o_cmd      = '0;
        o_rd_addr  = r_k[AW-1:0];
        o_comp_idx = k_m2[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_n        = clamp_n;
                    n_k        = '0;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (i_adv) begin
                    o_cmd.mul1 = 1'b1;
                    n_state    = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (i_adv) begin
                    o_cmd.mul2 = 1'b1;
                    n_state    = ST_SAT;
                end
            end
            ST_SAT: begin
                if (i_adv) begin
                    o_cmd.csat = 1'b1;
                    n_state    = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (i_adv) begin
                    o_cmd.step  = 1'b1;
                    o_cmd.rd_en = (r_k < r_n);
                    o_cmd.comp  = (r_k >= KW'(2));
                    o_cmd.first = (r_k == KW'(2));
                    o_cmd.last  = (k_m2 == r_n - KW'(1));
                    n_k         = r_k + KW'(1);
                    if (r_k == r_n + KW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= KW'(2);
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

// ===== hw/rtl/uas_dpath.sv =====
module uas_dpath
    import uas_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [$clog2(MAX_CELLS)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_CELLS)-1:0] i_comp_idx,
    input  logic [S_DATA_W-1:0]          i_item,
    input  logic [ICS_W-1:0]             i_inv_spacing,
    input  logic                         i_out_ready,
    output logic                         o_adv,
    output logic                         o_out_valid,
    output logic [FRAC_W-1:0]            o_cell_value,
    output logic [POS_W-1:0]             o_cell_position,
    output logic                         o_last_cell
);

    localparam int AW = $clog2(MAX_CELLS);

    // Latched time step
    logic signed [VEL_W-1:0]  r_vel;
    logic        [DT_W-1:0]   r_dt;
    logic signed [FRAC_W-1:0] r_inflow;
    logic signed [FRAC_W-1:0] r_outflow;

    // Courant number pipeline
    logic signed [VEL_W+DT_W:0]   mul1;
    logic signed [VEL_W+DT_W:0]   r_p;
    logic signed [VEL_W-1:0]      q;
    logic signed [VEL_W+ICS_W:0]  mul2;
    logic signed [VEL_W+ICS_W:0]  r_craw;
    logic signed [COUR_W-1:0]     r_c;
    logic                         c_hi;
    logic                         c_lo;

    // Row store and its read port
    logic [FRAC_W-1:0]    r_mem [MAX_CELLS];
    logic [MAX_CELLS-1:0] r_mem_vld;
    logic [FRAC_W-1:0]    r_rd;

    // Neighbour window: old values of cells i-1 and i
    logic signed [FRAC_W-1:0] r_prev;
    logic signed [FRAC_W-1:0] r_cur;

    // Update stage one
    logic                          pos_dir;
    logic                          pin;
    logic signed [FRAC_W-1:0]      pin_val;
    logic signed [FRAC_W:0]        diff;
    logic signed [COUR_W+FRAC_W:0] prod;
    logic                          r_s1_valid;
    logic                          r_s1_pin;
    logic                          r_s1_last;
    logic [AW-1:0]                 r_s1_idx;
    logic signed [FRAC_W-1:0]      r_s1_old;
    logic signed [COUR_W+FRAC_W:0] r_s1_prod;

    // Update stage two
    logic signed [COUR_W+FRAC_W-24:0] dlt;
    logic signed [COUR_W+FRAC_W-23:0] vsum;
    logic        [FRAC_W-1:0]          res;

    // Output register
    logic              r_out_valid;
    logic [FRAC_W-1:0] r_out_value;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;

    assign o_adv = !r_out_valid || i_out_ready;

    // Take in the fields of an accepted time step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vel     <= i_item[23:0];
            r_dt      <= i_item[47:24];
            r_inflow  <= i_item[63:48];
            r_outflow <= i_item[79:64];
        end
    end

    // Courant number: velocity times step, floor to Q.16, times inverse spacing
    assign mul1 = r_vel * $signed({1'b0, r_dt});
    assign q    = r_p[VEL_W+DT_W-1:DT_W];
    assign mul2 = q * $signed({1'b0, i_inv_spacing});
    assign c_hi = !r_craw[VEL_W+ICS_W] && (r_craw[VEL_W+ICS_W-1:COUR_W-1] != '0);
    assign c_lo = r_craw[VEL_W+ICS_W] && (r_craw[VEL_W+ICS_W-1:COUR_W-1] != '1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p <= mul1;
        end
        if (i_cmd.mul2) begin
            r_craw <= mul2;
        end
        if (i_cmd.csat) begin
            if (c_hi) begin
                r_c <= {1'b0, {(COUR_W-1){1'b1}}};
            end else if (c_lo) begin
                r_c <= {1'b1, {(COUR_W-1){1'b0}}};
            end else begin
                r_c <= r_craw[COUR_W-1:0];
            end
        end
    end

    // Read at most one old value per sweep step; a cell never written reads as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    // Shift the neighbour window
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= r_rd;
        end
    end

    // Upwind difference and its product with the Courant number
    assign pos_dir = !r_vel[VEL_W-1] && (r_vel != '0);
    always_comb begin
        if (pos_dir) begin
            pin     = i_cmd.first;
            pin_val = r_inflow;
            diff    = {r_cur[FRAC_W-1], r_cur} - {r_prev[FRAC_W-1], r_prev};
        end else begin
            pin     = i_cmd.last;
            pin_val = r_outflow;
            diff    = $signed({r_rd[FRAC_W-1], r_rd}) - {r_cur[FRAC_W-1], r_cur};
        end
    end
    assign prod = r_c * diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_adv) begin
            r_s1_valid <= i_cmd.comp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp) begin
            r_s1_pin  <= pin;
            r_s1_last <= i_cmd.last;
            r_s1_idx  <= i_comp_idx;
            r_s1_old  <= pin ? pin_val : r_cur;
            r_s1_prod <= prod;
        end
    end

    // New value: the boundary value for a pinned cell, else old minus the floored shifted product, saturated to Q2.14
    assign dlt  = r_s1_prod[COUR_W+FRAC_W:24];
    assign vsum = {{(COUR_W-22){r_s1_old[FRAC_W-1]}}, r_s1_old} - {dlt[COUR_W+FRAC_W-24], dlt};
    always_comb begin
        if (r_s1_pin) begin
            res = r_s1_old;
        end else if (!vsum[COUR_W+FRAC_W-23]
                     && (vsum[COUR_W+FRAC_W-24:FRAC_W-1] != '0)) begin
            res = {1'b0, {(FRAC_W-1){1'b1}}};
        end else if (vsum[COUR_W+FRAC_W-23]
                     && (vsum[COUR_W+FRAC_W-24:FRAC_W-1] != '1)) begin
            res = {1'b1, {(FRAC_W-1){1'b0}}};
        end else begin
            res = vsum[FRAC_W-1:0];
        end
    end

    // Write the new value back into the row store
    always_ff @(posedge i_clk) begin
        if (o_adv && r_s1_valid) begin
            r_mem[r_s1_idx] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (o_adv && r_s1_valid) begin
            r_mem_vld[r_s1_idx] <= 1'b1;
        end
    end

    // Output register holds a result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_s1_valid) begin
            r_out_value <= res;
            r_out_pos   <= POS_W'(r_s1_idx);
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_value    = r_out_value;
    assign o_cell_position = r_out_pos;
    assign o_last_cell     = r_out_last;

endmodule

// ===== tb/sv/upwind_advection_step_unit_tb.sv =====
module upwind_advection_step_unit_tb
    import uas_pkg::*;
();

    localparam int  ROW_DEPTH  = MAX_CELLS_DEF;
    localparam int  LONG_STALL = 400;
    localparam longint COUR_MAX = (longint'(1) <<< 31) - 1;
    localparam longint COUR_MIN = -(longint'(1) <<< 31);

    // One time step as offered on the input side.
    typedef struct {
        logic signed [VEL_W-1:0]  velocity;
        logic [DT_W-1:0]          time_step;
        logic signed [FRAC_W-1:0] inflow;
        logic signed [FRAC_W-1:0] outflow;
    } t_step;

    // One cell result as it should leave the block.
    typedef struct {
        logic [FRAC_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_cell_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // velocity [23:0], time_step [47:24], inflow_fraction [63:48],
    // outflow_fraction [79:64]
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // cell_value [15:0], cell_position [20:16], zero [23:21]
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = CFG_CELL_COUNT;
    logic [ICS_W-1:0]    i_cfg_data = '0;

    // Stimulus and expectation stores.
    t_step        steps_to_send[$];
    t_cell_result cells_due[$];
    t_step        cur_step = '{default: '0};
    bit           offering = 1'b0;
    bit           step_taken = 1'b0;

    // Idling controls, set per phase.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          long_stall_req = 1'b0;
    int          stall_left = 0;

    // Predictor copy of the row and of the registers.
    logic signed [FRAC_W-1:0] row_frac [ROW_DEPTH];
    logic [CNT_W-1:0]         cfg_cells;
    logic [ICS_W-1:0]         cfg_inv_dx;
    int                       mismatches = 0;

    upwind_advection_step_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the row by one upwind step and queue every emitted cell.
    function automatic void advect_row(input t_step st);
        longint                   vel;
        longint                   dt;
        longint                   courant;
        longint                   diff;
        longint                   upd;
        int                       n;
        logic signed [FRAC_W-1:0] nxt [ROW_DEPTH];
        t_cell_result             res;
        vel = longint'(st.velocity);
        dt  = longint'(st.time_step);
        n   = int'(cfg_cells);
        if (n < 2) n = 2;
        if (n > ROW_DEPTH) n = ROW_DEPTH;
        courant = ((vel * dt) >>> 24) * longint'(cfg_inv_dx);
        if (courant > COUR_MAX) courant = COUR_MAX;
        if (courant < COUR_MIN) courant = COUR_MIN;
        for (int i = 0; i < n; i++) begin
            if (vel > 0 && i == 0) begin
                nxt[i] = st.inflow;
            end else if (vel <= 0 && i == n - 1) begin
                nxt[i] = st.outflow;
            end else begin
                // Upwind difference taken from the values before this step.
                if (vel > 0)
                    diff = longint'(row_frac[i]) - longint'(row_frac[i-1]);
                else
                    diff = longint'(row_frac[i+1]) - longint'(row_frac[i]);
                upd = longint'(row_frac[i]) - ((courant * diff) >>> 24);
                if (upd > 32767) upd = 32767;
                if (upd < -32768) upd = -32768;
                nxt[i] = upd[FRAC_W-1:0];
            end
        end
        for (int i = 0; i < n; i++) begin
            row_frac[i]  = nxt[i];
            res.value    = nxt[i];
            res.position = i[POS_W-1:0];
            res.last     = (i == n - 1);
            cells_due.insert(cells_due.size(), res);
        end
    endfunction

    // Random time step: mostly moderate Courant numbers, the rest raw bits.
    function automatic t_step random_step();
        t_step       st;
        int unsigned mag;
        if ($urandom_range(9) < 6) begin
            mag = $urandom_range(1 << $urandom_range(18, 2));
            st.velocity  = $urandom_range(1) ? -VEL_W'(mag) : VEL_W'(mag);
            st.time_step = DT_W'($urandom_range(1 << 22));
            st.inflow    = $urandom_range(1) ? FRAC_W'($urandom_range(65535))
                                             : FRAC_W'($urandom_range(16384));
            st.outflow   = $urandom_range(1) ? FRAC_W'($urandom_range(65535))
                                             : -FRAC_W'($urandom_range(16384));
        end else begin
            st.velocity  = VEL_W'($urandom());
            st.time_step = DT_W'($urandom());
            st.inflow    = FRAC_W'($urandom());
            st.outflow   = FRAC_W'($urandom());
        end
        return st;
    endfunction

    function automatic void queue_step(input int vel, input int dt, input int fin,
                                       input int fout);
        t_step st;
        st.velocity  = vel[VEL_W-1:0];
        st.time_step = dt[DT_W-1:0];
        st.inflow    = fin[FRAC_W-1:0];
        st.outflow   = fout[FRAC_W-1:0];
        steps_to_send.insert(steps_to_send.size(), st);
    endfunction

    // Sender: offer the next time step, holding it until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            offering = 1'b0;
        end else begin
            if (step_taken) begin
                offering   = 1'b0;
                step_taken = 1'b0;
            end
            if (!offering && steps_to_send.size() > 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                cur_step = steps_to_send.pop_front();
                offering = 1'b1;
            end
        end
        s_tvalid <= offering;
        s_tdata  <= {cur_step.outflow, cur_step.inflow, cur_step.time_step,
                     cur_step.velocity};
    end

    // Receiver: random stalls, and a long hold-off counted here on request.
    always @(negedge i_clk) begin
        if (long_stall_req) begin
            stall_left     = LONG_STALL;
            long_stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: register writes, input transfers and result checks.
    always @(posedge i_clk) begin
        t_cell_result due;
        if (!i_rst_n) begin
            cfg_cells  = CELL_COUNT_RST;
            cfg_inv_dx = INV_SPACING_RST;
            foreach (row_frac[i]) row_frac[i] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CELL_COUNT)
                    cfg_cells = i_cfg_data[CNT_W-1:0];
                else
                    cfg_inv_dx = i_cfg_data;
            end
            if (m_tvalid && m_tready) begin
                if (cells_due.size() == 0) begin
                    $error("cell result transfer with none expected: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    due = cells_due.pop_front();
                    if (m_tdata[FRAC_W-1:0] !== due.value) begin
                        $error("cell_value: expected %0d, got %0d",
                               $signed(due.value), $signed(m_tdata[FRAC_W-1:0]));
                        mismatches++;
                    end
                    if (m_tdata[FRAC_W+POS_W-1:FRAC_W] !== due.position) begin
                        $error("cell_position: expected %0d, got %0d",
                               due.position, m_tdata[FRAC_W+POS_W-1:FRAC_W]);
                        mismatches++;
                    end
                    if (m_tlast !== due.last) begin
                        $error("last_cell: expected %0d, got %0d", due.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advect_row(cur_step);
                step_taken = 1'b1;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [ICS_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Wait until every queued step has gone in and every cell has come out.
    task automatic drain();
        while (steps_to_send.size() != 0 || offering || cells_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned counts   [8];
        int unsigned spacings [8];
        int          per_phase;
        counts      = '{32, 0, 1, 63, 2, 33, 17, 5};
        spacings    = '{24'hFFFFFF, 0, 1, 256, 0, 4096, 0, 256};
        spacings[4] = $urandom_range(24'hFFFFFF, 1);
        spacings[6] = $urandom_range(1 << 16, 1);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed steps under the reset settings: field extremes, both
        // directions, zero velocity, zero step, saturating Courant numbers.
        queue_step(8388607, 16777215, 32767, -32768);
        queue_step(-8388608, 16777215, -32768, 32767);
        queue_step(8388607, 16777215, -32768, 32767);
        queue_step(-8388608, 16777215, 32767, -32768);
        queue_step(0, 16777215, 16'h1234, -1);
        queue_step(1, 0, -1, 16'h5A5A);
        queue_step(-1, 16777215, 16'h4000, -16384);
        queue_step(65536, 1 << 23, 16384, 0);
        queue_step(65536, 1 << 23, 16384, 0);
        queue_step(-65536, 1 << 23, 0, -16384);
        queue_step(-65536, 1 << 23, 0, -16384);
        queue_step(8388607, 1, 32767, 32767);
        queue_step(-8388608, 1, -32768, -32768);
        queue_step(131072, 1 << 23, 32767, -32768);
        queue_step(-131072, 1 << 23, -32768, 32767);
        queue_step(24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA);
        queue_step(24'h2AAAAA, 24'h555555, 16'h2AAA, 16'h5555);
        drain();

        // Random phases, each under its own register setting and idling mode.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_CELL_COUNT, ICS_W'(counts[ph]));
            write_reg(CFG_INV_SPACING, ICS_W'(spacings[ph]));
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
            endcase
            per_phase = 35;
            // Long receiver hold-off while the sender keeps offering steps.
            if (ph == 3) begin
                tx_idle_pct    = 0;
                rx_stall_pct   = 0;
                long_stall_req = 1'b1;
            end
            repeat (per_phase) steps_to_send.insert(steps_to_send.size(), random_step());
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && cells_due.size() == 0)
            $display("upwind_advection_step_unit verification clean");
        else
            $display("upwind_advection_step_unit verification failed");
        $finish;
    end

    // Run-time guard.
    initial begin
        #8000000;
        $display("upwind_advection_step_unit verification failed");
        $finish;
    end

endmodule
